[hw/rtl/pbfs_pkg.sv]
`default_nettype none

package pbfs_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RENDER_BG  = 2'd0;
    localparam logic [1:0] CFG_RENDER_SPR = 2'd1;
    localparam logic [1:0] CFG_BG_TABLE   = 2'd2;
    localparam logic [1:0] CFG_TEMP_ADDR  = 2'd3;

    // Video memory bases and masks
    localparam logic [13:0] NT_BASE   = 14'h2000;
    localparam logic [13:0] AT_BASE   = 14'h23C0;
    localparam logic [13:0] NT_OFFSET = 14'h0FFF;
    localparam logic [14:0] COPY_X_MASK = 15'h041F;
    localparam logic [14:0] COPY_Y_MASK = 15'h7BE0;

    // Coarse Y wrap points
    localparam logic [4:0] COARSE_Y_LAST = 5'd29;
    localparam logic [4:0] COARSE_Y_MAX  = 5'd31;

    // Dot boundaries of the fetch sequence
    localparam logic [8:0] DOT_RUN_A_LO = 9'd2;
    localparam logic [8:0] DOT_RUN_A_HI = 9'd258;
    localparam logic [8:0] DOT_RUN_B_LO = 9'd321;
    localparam logic [8:0] DOT_RUN_B_HI = 9'd338;
    localparam logic [8:0] DOT_STEP_Y   = 9'd256;
    localparam logic [8:0] DOT_COPY_X   = 9'd257;
    localparam logic [8:0] DOT_NT_EXTRA = 9'd340;
    localparam logic [8:0] DOT_COPY_Y_LO = 9'd280;
    localparam logic [8:0] DOT_COPY_Y_HI = 9'd305;

    // Phase within the 8-dot fetch group, (dot - 1) mod 8
    localparam logic [2:0] PH_NT   = 3'd0;
    localparam logic [2:0] PH_AT   = 3'd2;
    localparam logic [2:0] PH_PLO  = 3'd4;
    localparam logic [2:0] PH_PHI  = 3'd6;
    localparam logic [2:0] PH_INCX = 3'd7;

    // Kind of fetch whose byte is due on the next dot
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_NT,
        KIND_AT,
        KIND_PLO,
        KIND_PHI
    } kind_t;

    typedef struct packed {
        logic        render_bg;
        logic        render_spr;
        logic        bg_table;
        logic [14:0] temp_addr;
    } cfg_t;

    typedef struct packed {
        logic        fetch_valid;
        logic [13:0] fetch_addr;
        logic [14:0] scroll_addr;
        logic [15:0] shift_pat_lo;
        logic [15:0] shift_pat_hi;
        logic [15:0] shift_attr_lo;
        logic [15:0] shift_attr_hi;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/pbfs_cfg_regs.sv]
`default_nettype none

module pbfs_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [14:0]    cfg_data,
    output pbfs_pkg::cfg_t      cfg
);

    pbfs_pkg::cfg_t cfg_reg;
    pbfs_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pbfs_pkg::CFG_RENDER_BG:  cfg_next.render_bg  = cfg_data[0];
                pbfs_pkg::CFG_RENDER_SPR: cfg_next.render_spr = cfg_data[0];
                pbfs_pkg::CFG_BG_TABLE:   cfg_next.bg_table   = cfg_data[0];
                pbfs_pkg::CFG_TEMP_ADDR:  cfg_next.temp_addr  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

[hw/rtl/pbfs_datapath.sv]
`default_nettype none

module pbfs_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire pbfs_pkg::cfg_t cfg,
    input  wire logic [8:0]     scanline,
    input  wire logic [8:0]     dot,
    input  wire logic [7:0]     mem_data,
    output pbfs_pkg::result_t   result
);

    logic [14:0]      scroll_reg, scroll_next;
    logic [7:0]       tile_num_reg, tile_num_next;
    logic [1:0]       tile_pal_reg, tile_pal_next;
    logic [7:0]       tile_lo_reg, tile_lo_next;
    logic [7:0]       tile_hi_reg, tile_hi_next;
    logic [3:0][15:0] shift_reg, shift_next;
    pbfs_pkg::kind_t  pend_kind_reg, pend_kind_next;
    logic [1:0]       pend_quad_reg, pend_quad_next;

    logic [8:0]       dot_eff;
    logic [2:0]       phase;
    logic             in_run;
    logic             pre_line;
    logic             rendering;
    pbfs_pkg::kind_t  fetch_kind;
    logic [1:0]       fetch_quad;
    logic [13:0]      fetch_addr;
    logic [13:0]      pat_base;

    // Coarse X increment with horizontal nametable switch
    function automatic logic [14:0] step_x(input logic [14:0] a);
        logic [14:0] r;
        r = a;
        if (a[4:0] == pbfs_pkg::COARSE_Y_MAX)
        begin
            r[4:0] = 5'd0;
            r[10]  = ~a[10];
        end
        else
            r = a + 15'd1;
        return r;
    endfunction

    // Fine / coarse Y increment, 29 wraps with nametable switch, 31 wraps plain
    function automatic logic [14:0] step_y(input logic [14:0] a);
        logic [14:0] r;
        r = a;
        if (a[14:12] != 3'd7)
            r[14:12] = a[14:12] + 3'd1;
        else
        begin
            r[14:12] = 3'd0;
            r[9:5]   = 5'd0;
            if (a[9:5] == pbfs_pkg::COARSE_Y_LAST)
                r[11] = ~a[11];
            else if (a[9:5] != pbfs_pkg::COARSE_Y_MAX)
                r[9:5] = a[9:5] + 5'd1;
        end
        return r;
    endfunction

    assign rendering = cfg.render_bg | cfg.render_spr;
    assign pre_line  = (scanline == 9'h1FF);
    // dot 0 of line 0 behaves as dot 1
    assign dot_eff   = ((scanline == 9'd0) && (dot == 9'd0)) ? 9'd1 : dot;
    assign phase     = dot_eff[2:0] - 3'd1;
    assign in_run    = ((dot_eff >= pbfs_pkg::DOT_RUN_A_LO) && (dot_eff < pbfs_pkg::DOT_RUN_A_HI))
                    || ((dot_eff >= pbfs_pkg::DOT_RUN_B_LO) && (dot_eff < pbfs_pkg::DOT_RUN_B_HI));

    // One dot of the background pipeline
    always_comb
    begin
        tile_num_next = tile_num_reg;
        tile_pal_next = tile_pal_reg;
        tile_lo_next  = tile_lo_reg;
        tile_hi_next  = tile_hi_reg;
        shift_next    = shift_reg;
        scroll_next   = scroll_reg;
        fetch_kind    = pbfs_pkg::KIND_NONE;
        fetch_quad    = 2'd0;
        fetch_addr    = 14'd0;

        // latch the byte of last dot's fetch
        case (pend_kind_reg)
            pbfs_pkg::KIND_NT:  tile_num_next = mem_data;
            pbfs_pkg::KIND_AT:
            begin
                case (pend_quad_reg)
                    2'd0:    tile_pal_next = mem_data[1:0];
                    2'd1:    tile_pal_next = mem_data[3:2];
                    2'd2:    tile_pal_next = mem_data[5:4];
                    default: tile_pal_next = mem_data[7:6];
                endcase
            end
            pbfs_pkg::KIND_PLO: tile_lo_next = mem_data;
            pbfs_pkg::KIND_PHI: tile_hi_next = mem_data;
            default:            tile_num_next = tile_num_reg;
        endcase

        pat_base = {1'b0, cfg.bg_table, 12'h000} + {2'b00, tile_num_next, 4'h0}
                 + {11'd0, scroll_next[14:12]};

        // fetch group
        if (in_run)
        begin
            if (cfg.render_bg)
            begin
                for (int i = 0; i < 4; i++)
                    shift_next[i] = {shift_next[i][14:0], 1'b0};
            end
            case (phase)
                pbfs_pkg::PH_NT:
                begin
                    shift_next[0][7:0] = tile_lo_next;
                    shift_next[1][7:0] = tile_hi_next;
                    shift_next[2][7:0] = {8{tile_pal_next[0]}};
                    shift_next[3][7:0] = {8{tile_pal_next[1]}};
                    fetch_addr = pbfs_pkg::NT_BASE | (scroll_next[13:0] & pbfs_pkg::NT_OFFSET);
                    fetch_kind = pbfs_pkg::KIND_NT;
                end
                pbfs_pkg::PH_AT:
                begin
                    fetch_addr = pbfs_pkg::AT_BASE | {2'b00, scroll_next[11:10], 10'd0}
                               | {8'd0, scroll_next[9:7], 3'd0} | {11'd0, scroll_next[4:2]};
                    fetch_quad = {scroll_next[6], scroll_next[1]};
                    fetch_kind = pbfs_pkg::KIND_AT;
                end
                pbfs_pkg::PH_PLO:
                begin
                    fetch_addr = pat_base;
                    fetch_kind = pbfs_pkg::KIND_PLO;
                end
                pbfs_pkg::PH_PHI:
                begin
                    fetch_addr = pat_base + 14'd8;
                    fetch_kind = pbfs_pkg::KIND_PHI;
                end
                pbfs_pkg::PH_INCX:
                begin
                    if (rendering)
                        scroll_next = step_x(scroll_next);
                end
                default: fetch_kind = pbfs_pkg::KIND_NONE;
            endcase
        end

        // end of visible part of the line
        if ((dot_eff == pbfs_pkg::DOT_STEP_Y) && rendering)
            scroll_next = step_y(scroll_next);
        if (dot_eff == pbfs_pkg::DOT_COPY_X)
        begin
            shift_next[0][7:0] = tile_lo_next;
            shift_next[1][7:0] = tile_hi_next;
            shift_next[2][7:0] = {8{tile_pal_next[0]}};
            shift_next[3][7:0] = {8{tile_pal_next[1]}};
            if (rendering)
                scroll_next = (scroll_next & ~pbfs_pkg::COPY_X_MASK)
                            | (cfg.temp_addr & pbfs_pkg::COPY_X_MASK);
        end

        // dummy nametable reads at line end
        if ((dot_eff == pbfs_pkg::DOT_RUN_B_HI) || (dot_eff == pbfs_pkg::DOT_NT_EXTRA))
        begin
            fetch_addr = pbfs_pkg::NT_BASE | (scroll_next[13:0] & pbfs_pkg::NT_OFFSET);
            fetch_kind = pbfs_pkg::KIND_NT;
        end

        // vertical copy on the pre-render line
        if (pre_line && rendering && (dot_eff >= pbfs_pkg::DOT_COPY_Y_LO)
            && (dot_eff < pbfs_pkg::DOT_COPY_Y_HI))
            scroll_next = (scroll_next & pbfs_pkg::COPY_X_MASK)
                        | (cfg.temp_addr & pbfs_pkg::COPY_Y_MASK);

        pend_kind_next = fetch_kind;
        pend_quad_next = (fetch_kind != pbfs_pkg::KIND_NONE) ? fetch_quad : pend_quad_reg;
    end

    // Result of this dot
    always_comb
    begin
        result.fetch_valid   = (fetch_kind != pbfs_pkg::KIND_NONE);
        result.fetch_addr    = result.fetch_valid ? fetch_addr : 14'd0;
        result.scroll_addr   = scroll_next;
        result.shift_pat_lo  = shift_next[0];
        result.shift_pat_hi  = shift_next[1];
        result.shift_attr_lo = shift_next[2];
        result.shift_attr_hi = shift_next[3];
    end

    // State advances once per dot handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_reg    <= '0;
            tile_num_reg  <= '0;
            tile_pal_reg  <= '0;
            tile_lo_reg   <= '0;
            tile_hi_reg   <= '0;
            shift_reg     <= '0;
            pend_kind_reg <= pbfs_pkg::KIND_NONE;
            pend_quad_reg <= '0;
        end
        else if (step_en)
        begin
            scroll_reg    <= scroll_next;
            tile_num_reg  <= tile_num_next;
            tile_pal_reg  <= tile_pal_next;
            tile_lo_reg   <= tile_lo_next;
            tile_hi_reg   <= tile_hi_next;
            shift_reg     <= shift_next;
            pend_kind_reg <= pend_kind_next;
            pend_quad_reg <= pend_quad_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ppu_background_fetch_scroll.sv]
// Background fetch and scroll unit, one video dot per transaction.
// Slave stream s_*: one dot per transaction (scanline, dot, and the memory
// byte read for the fetch address given out with the previous dot).
// Master stream m_*: one result per dot: fetch flag in tuser, fetch address,
// running scroll address and the four background shifters in tdata.
// Config channel cfg_*: index 0 render_background, 1 render_sprites,
// 2 bg_pattern_table, 3 temp_address; always ready, write only while idle.
// Path: an accepted dot is stored in the input register, and its result is
// then captured in the output result register.
// Throughput: one dot per cycle while m_tready is high; the per-dot logic
// between the input and result registers is a single pass.
// Stall: while m_tready is low the result holds, one more dot can wait in
// the input register, then s_tready drops until the result is taken.
// Reset: scroll address, tile latches, shifters and config clear, no fetch
// pending, both registers empty.
`default_nettype none

module ppu_background_fetch_scroll (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // tdata: scanline[8:0], dot[17:9], mem_data[25:18], zero[31:26]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,
    // tdata: fetch_addr[13:0], scroll_addr[28:14], shift_pat_lo[44:29],
    // shift_pat_hi[60:45], shift_attr_lo[76:61], shift_attr_hi[92:77], zero[95:93]
    // tuser: fetch_valid[0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [14:0]  cfg_data
);

    pbfs_pkg::cfg_t    cfg;
    pbfs_pkg::result_t result;
    pbfs_pkg::result_t res_reg;

    logic        in_valid_reg, in_valid_next;
    logic        m_valid_reg, m_valid_next;
    logic [8:0]  scanline_reg;
    logic [8:0]  dot_reg;
    logic [7:0]  mem_data_reg;
    logic        out_free;
    logic        step_en;
    logic        s_accept;

    pbfs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbfs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .cfg      (cfg),
        .scanline (scanline_reg),
        .dot      (dot_reg),
        .mem_data (mem_data_reg),
        .result   (result)
    );

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign step_en  = in_valid_reg && out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (step_en)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Input and result payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            scanline_reg <= s_tdata[8:0];
            dot_reg      <= s_tdata[17:9];
            mem_data_reg <= s_tdata[25:18];
        end
        if (step_en)
            res_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.fetch_valid;
    assign m_tdata  = {3'b000, res_reg.shift_attr_hi, res_reg.shift_attr_lo,
                       res_reg.shift_pat_hi, res_reg.shift_pat_lo,
                       res_reg.scroll_addr, res_reg.fetch_addr};

`ifndef NO_ASSERTIONS
    // no fetch means a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[13:0] == 14'd0))
        else $error("fetch address set without a fetch");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // a waiting dot is kept while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("waiting dot lost during stall");

    // a waiting dot refills the result register as it drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && in_valid_reg) |=> m_tvalid)
        else $error("result bubble with a dot waiting");
`endif

endmodule

`default_nettype wire

[tb/tb_ppu_background_fetch_scroll.sv]
`default_nettype none

module tb_ppu_background_fetch_scroll;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8:0] PRE_LINE = 9'h1FF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = pbfs_pkg::CFG_RENDER_BG;
    logic [14:0] cfg_data = '0;

    ppu_background_fetch_scroll dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow of the block's state and configuration
    pbfs_pkg::cfg_t    cfg_shadow = '0;
    logic [14:0]       scroll_q = '0;
    logic [7:0]        tile_num = '0;
    logic [1:0]        tile_pal = '0;
    logic [7:0]        tile_lo = '0;
    logic [7:0]        tile_hi = '0;
    logic [15:0]       bg_shift [4] = '{default: '0};
    pbfs_pkg::kind_t   fetch_kind = pbfs_pkg::KIND_NONE;
    logic [1:0]        fetch_quad = '0;

    pbfs_pkg::result_t dot_results_due [$];
    int                mismatch_count = 0;
    int                dots_sent = 0;
    logic              idle_on = 1'b1;
    int                stall_left = 0;
    pbfs_pkg::result_t seen_res;
    pbfs_pkg::result_t due_res;

    // Latched tile bytes into the low halves of the shifters
    function automatic void load_next_tile();
        bg_shift[0] = {bg_shift[0][15:8], tile_lo};
        bg_shift[1] = {bg_shift[1][15:8], tile_hi};
        bg_shift[2] = {bg_shift[2][15:8], {8{tile_pal[0]}}};
        bg_shift[3] = {bg_shift[3][15:8], {8{tile_pal[1]}}};
    endfunction

    // Advances the shadow by one dot and returns the result it should give
    function automatic pbfs_pkg::result_t compute_dot_result(logic [8:0] scan,
                                                             logic [8:0] dot_in,
                                                             logic [7:0] data);
        pbfs_pkg::result_t res;
        logic [8:0]        d;
        logic [14:0]       v;
        logic [2:0]        grp_phase;
        logic [1:0]        quad;
        logic [4:0]        cy;
        logic [13:0]       addr;
        logic [13:0]       pat_base;
        pbfs_pkg::kind_t   kind;
        logic              drawing;

        d = dot_in;
        addr = '0;
        quad = '0;
        kind = pbfs_pkg::KIND_NONE;
        drawing = cfg_shadow.render_bg | cfg_shadow.render_spr;

        // byte for the fetch issued on the previous dot
        case (fetch_kind)
            pbfs_pkg::KIND_NT:  tile_num = data;
            pbfs_pkg::KIND_AT:  tile_pal = data[2 * fetch_quad +: 2];
            pbfs_pkg::KIND_PLO: tile_lo = data;
            pbfs_pkg::KIND_PHI: tile_hi = data;
            default: ;
        endcase
        fetch_kind = pbfs_pkg::KIND_NONE;

        // dot zero of line zero is skipped over
        if (scan == 9'd0 && d == 9'd0)
            d = 9'd1;

        if ((d >= pbfs_pkg::DOT_RUN_A_LO && d < pbfs_pkg::DOT_RUN_A_HI)
            || (d >= pbfs_pkg::DOT_RUN_B_LO && d < pbfs_pkg::DOT_RUN_B_HI))
        begin
            if (cfg_shadow.render_bg)
            begin
                for (int i = 0; i < 4; i++)
                    bg_shift[i] = bg_shift[i] << 1;
            end
            v = scroll_q;
            grp_phase = d[2:0] - 3'd1;
            pat_base = {1'b0, cfg_shadow.bg_table, 12'h000} + {2'b00, tile_num, 4'h0}
                       + {11'd0, v[14:12]};
            case (grp_phase)
                pbfs_pkg::PH_NT:
                begin
                    load_next_tile();
                    addr = pbfs_pkg::NT_BASE | {2'b00, v[11:0]};
                    kind = pbfs_pkg::KIND_NT;
                end
                pbfs_pkg::PH_AT:
                begin
                    addr = pbfs_pkg::AT_BASE | {2'b00, v[11:10], 4'h0, v[9:7], v[4:2]};
                    quad = {v[6], v[1]};
                    kind = pbfs_pkg::KIND_AT;
                end
                pbfs_pkg::PH_PLO:
                begin
                    addr = pat_base;
                    kind = pbfs_pkg::KIND_PLO;
                end
                pbfs_pkg::PH_PHI:
                begin
                    addr = pat_base + 14'd8;
                    kind = pbfs_pkg::KIND_PHI;
                end
                pbfs_pkg::PH_INCX:
                begin
                    // coarse X wraps into the other horizontal nametable
                    if (drawing)
                    begin
                        if (&scroll_q[4:0])
                            scroll_q = {scroll_q[14:5], 5'd0} ^ 15'h0400;
                        else
                            scroll_q = scroll_q + 15'd1;
                    end
                end
                default: ;
            endcase
        end

        // fine Y, then coarse Y with the 29 and 31 wraps
        if (d == pbfs_pkg::DOT_STEP_Y && drawing)
        begin
            if (scroll_q[14:12] != 3'd7)
                scroll_q[14:12] = scroll_q[14:12] + 3'd1;
            else
            begin
                scroll_q[14:12] = 3'd0;
                cy = scroll_q[9:5];
                scroll_q[9:5] = 5'd0;
                if (cy == pbfs_pkg::COARSE_Y_LAST)
                    scroll_q[11] = ~scroll_q[11];
                else if (cy != pbfs_pkg::COARSE_Y_MAX)
                    scroll_q[9:5] = cy + 5'd1;
            end
        end

        if (d == pbfs_pkg::DOT_COPY_X)
        begin
            load_next_tile();
            if (drawing)
                scroll_q = (scroll_q & ~pbfs_pkg::COPY_X_MASK)
                           | (cfg_shadow.temp_addr & pbfs_pkg::COPY_X_MASK);
        end

        if (d == pbfs_pkg::DOT_RUN_B_HI || d == pbfs_pkg::DOT_NT_EXTRA)
        begin
            addr = pbfs_pkg::NT_BASE | {2'b00, scroll_q[11:0]};
            kind = pbfs_pkg::KIND_NT;
        end

        if (scan == PRE_LINE && d >= pbfs_pkg::DOT_COPY_Y_LO && d < pbfs_pkg::DOT_COPY_Y_HI
            && drawing)
            scroll_q = (scroll_q & pbfs_pkg::COPY_X_MASK)
                       | (cfg_shadow.temp_addr & pbfs_pkg::COPY_Y_MASK);

        if (kind != pbfs_pkg::KIND_NONE)
        begin
            fetch_kind = kind;
            fetch_quad = quad;
        end

        res.fetch_valid   = (kind != pbfs_pkg::KIND_NONE);
        res.fetch_addr    = res.fetch_valid ? addr : 14'd0;
        res.scroll_addr   = scroll_q;
        res.shift_pat_lo  = bg_shift[0];
        res.shift_pat_hi  = bg_shift[1];
        res.shift_attr_lo = bg_shift[2];
        res.shift_attr_hi = bg_shift[3];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sink side: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 10);
        if (stall_left > 0 && idle_on)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker: every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_res.fetch_valid   = m_tuser[0];
            seen_res.fetch_addr    = m_tdata[13:0];
            seen_res.scroll_addr   = m_tdata[28:14];
            seen_res.shift_pat_lo  = m_tdata[44:29];
            seen_res.shift_pat_hi  = m_tdata[60:45];
            seen_res.shift_attr_lo = m_tdata[76:61];
            seen_res.shift_attr_hi = m_tdata[92:77];
            if (dot_results_due.size() == 0)
                report_mismatch("result with no dot outstanding");
            else
            begin
                due_res = dot_results_due.pop_front();
                if (seen_res.fetch_valid !== due_res.fetch_valid)
                    report_mismatch($sformatf("fetch_valid %0h, want %0h",
                                    seen_res.fetch_valid, due_res.fetch_valid));
                if (seen_res.fetch_addr !== due_res.fetch_addr)
                    report_mismatch($sformatf("fetch_addr %h, want %h",
                                    seen_res.fetch_addr, due_res.fetch_addr));
                if (seen_res.scroll_addr !== due_res.scroll_addr)
                    report_mismatch($sformatf("scroll_addr %h, want %h",
                                    seen_res.scroll_addr, due_res.scroll_addr));
                if (seen_res.shift_pat_lo !== due_res.shift_pat_lo)
                    report_mismatch($sformatf("shift_pat_lo %h, want %h",
                                    seen_res.shift_pat_lo, due_res.shift_pat_lo));
                if (seen_res.shift_pat_hi !== due_res.shift_pat_hi)
                    report_mismatch($sformatf("shift_pat_hi %h, want %h",
                                    seen_res.shift_pat_hi, due_res.shift_pat_hi));
                if (seen_res.shift_attr_lo !== due_res.shift_attr_lo)
                    report_mismatch($sformatf("shift_attr_lo %h, want %h",
                                    seen_res.shift_attr_lo, due_res.shift_attr_lo));
                if (seen_res.shift_attr_hi !== due_res.shift_attr_hi)
                    report_mismatch($sformatf("shift_attr_hi %h, want %h",
                                    seen_res.shift_attr_hi, due_res.shift_attr_hi));
            end
        end
    end

    // One dot transaction; valid stays high for a following dot
    task automatic send_dot(input logic signed [8:0] scan, input logic [8:0] dot_no,
                            input logic [7:0] data);
        // the closing stretch of the run goes without idling
        if (dots_sent >= 640)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, dot_no, scan};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        dot_results_due.push_back(compute_dot_result(scan, dot_no, data));
        dots_sent++;
    endtask

    // Stop sending and let every outstanding result come out
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (dot_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pbfs_pkg::CFG_RENDER_BG:  cfg_shadow.render_bg  = value[0];
            pbfs_pkg::CFG_RENDER_SPR: cfg_shadow.render_spr = value[0];
            pbfs_pkg::CFG_BG_TABLE:   cfg_shadow.bg_table   = value[0];
            pbfs_pkg::CFG_TEMP_ADDR:  cfg_shadow.temp_addr  = value;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic bg, input logic spr, input logic tbl,
                                input logic [14:0] temp);
        drain_pipeline();
        write_reg(pbfs_pkg::CFG_RENDER_BG, {14'd0, bg});
        write_reg(pbfs_pkg::CFG_RENDER_SPR, {14'd0, spr});
        write_reg(pbfs_pkg::CFG_BG_TABLE, {14'd0, tbl});
        write_reg(pbfs_pkg::CFG_TEMP_ADDR, temp);
        cfg_valid <= 1'b0;
    endtask

    // Reset configuration: fetches still go out, no scroll movement, no shifting
    task automatic test_power_on();
        send_dot(0, 0, 8'hFF);
        send_dot(0, 2, 8'hA5);
        send_dot(0, 3, 8'h00);
        send_dot(0, 4, 8'hE4);
        send_dot(-1, 280, 8'h3C);
        send_dot(240, 338, 8'h00);
        send_dot(-256, 340, 8'hFF);
        send_dot(5, 511, 8'h81);
        send_dot(5, 0, 8'h5A);
    endtask

    // Copies from temp, both coarse Y wraps, coarse X wrap and one fetch group
    task automatic test_scroll_wrap();
        write_config(1'b1, 1'b0, 1'b1, 15'h7FBF);
        send_dot(-1, 280, 8'($urandom_range(0, 255)));
        send_dot(-1, 257, 8'($urandom_range(0, 255)));
        send_dot(-1, 256, 8'($urandom_range(0, 255)));
        for (int d = 1; d <= 9; d++)
            send_dot(0, 9'(d), 8'($urandom_range(0, 255)));
        send_dot(-1, 304, 8'($urandom_range(0, 255)));
        send_dot(-1, 305, 8'($urandom_range(0, 255)));
        // coarse Y of 31 wraps to zero with no nametable switch
        write_config(1'b1, 1'b0, 1'b0, 15'h73FF);
        send_dot(-1, 290, 8'($urandom_range(0, 255)));
        send_dot(-1, 256, 8'($urandom_range(0, 255)));
        send_dot(3, 338, 8'($urandom_range(0, 255)));
        send_dot(3, 339, 8'($urandom_range(0, 255)));
        send_dot(3, 340, 8'($urandom_range(0, 255)));
    endtask

    // Sprites alone move the scroll address but never shift; with neither enabled it stays put
    task automatic test_sprite_only_scroll();
        write_config(1'b0, 1'b1, 1'b0, 15'h0000);
        send_dot(7, 8, 8'h12);
        send_dot(7, 256, 8'h34);
        send_dot(7, 257, 8'h56);
        write_config(1'b0, 1'b0, 1'b1, 15'h7FFF);
        send_dot(-1, 256, 8'h78);
        send_dot(-1, 280, 8'h9A);
    endtask

    // Runs of consecutive dots from random places in the frame, some noise
    task automatic test_random_frames();
        int          scan;
        int          dot_no;
        int          run_len;
        int          phase_len;
        int          n;
        logic [14:0] temp;

        while (dots_sent < 750)
        begin
            case ($urandom_range(0, 3))
                0:       temp = 15'h0000;
                1:       temp = 15'h7FFF;
                default: temp = 15'($urandom_range(0, 32767));
            endcase
            write_config($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), temp);
            phase_len = $urandom_range(60, 110);
            n = 0;
            while (n < phase_len && dots_sent < 750)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_dot(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                             8'($urandom_range(0, 255)));
                    n++;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       scan = -1;
                        1:       scan = 0;
                        default: scan = $urandom_range(0, 239);
                    endcase
                    dot_no = $urandom_range(0, 340);
                    run_len = ($urandom_range(0, 7) == 0) ? 341 : $urandom_range(8, 64);
                    for (int k = 0; k < run_len && dots_sent < 750; k++)
                    begin
                        send_dot(9'(scan), 9'(dot_no), 8'($urandom_range(0, 255)));
                        n++;
                        dot_no++;
                        if (dot_no > 340)
                        begin
                            dot_no = 0;
                            scan = (scan == 239) ? -1 : scan + 1;
                        end
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on();
        test_scroll_wrap();
        test_sprite_only_scroll();
        test_random_frames();
        drain_pipeline();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("ppu_background_fetch_scroll verification clean");
        else
            $display("ppu_background_fetch_scroll verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("ppu_background_fetch_scroll verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/pbfs_pkg.sv
hw/rtl/pbfs_cfg_regs.sv
hw/rtl/pbfs_datapath.sv
hw/rtl/ppu_background_fetch_scroll.sv
tb/tb_ppu_background_fetch_scroll.sv
